// ===== rtl/tcmk_pkg.sv =====
// Package for the triangle centroid curve key block.
// Holds key widths, register indexes and reset constants; depends on nothing.
package tcmk_pkg;

	localparam int KEY_W          = 60;
	localparam int BITS_PER_LEVEL = 3;
	localparam int OUT_TDATA_W    = ((KEY_W + 7) / 8) * 8;
	localparam int LEVEL_CNT_W    = 5;
	localparam int NUM_REGS       = 5;
	localparam int IDX_W          = $clog2(NUM_REGS);

	localparam logic [63:0]            ONE_FIXED       = 64'd1073741824;
	localparam logic [LEVEL_CNT_W-1:0] LEVEL_CNT_RESET = 5'd20;

	typedef enum logic [IDX_W-1:0] {
		REG_LEFT_EDGE   = 3'd0,
		REG_RIGHT_EDGE  = 3'd1,
		REG_BOTTOM_EDGE = 3'd2,
		REG_TOP_EDGE    = 3'd3,
		REG_LEVEL_COUNT = 3'd4
	} reg_idx_t;

	// Bit 2 of every level is never set in a key.
	function automatic logic [KEY_W-1:0] key_spare_mask();
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_W; i++) begin
			if ((i % BITS_PER_LEVEL) == 2) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/tcmk_cfg_regs.sv =====
// Configuration register file on an APB-style port: bounding box and level count.
// Depends on tcmk_pkg for register indexes and reset constants.
module tcmk_cfg_regs #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [tcmk_pkg::IDX_W+((COORD_WIDTH>32)?3:2)-1:0] paddr,
	input  logic [((COORD_WIDTH>32)?64:32)-1:0]       pwdata,
	output logic [((COORD_WIDTH>32)?64:32)-1:0]       prdata,
	output logic                                      pready,
	output logic [COORD_WIDTH-1:0]                    left_edge,
	output logic [COORD_WIDTH-1:0]                    right_edge,
	output logic [COORD_WIDTH-1:0]                    bottom_edge,
	output logic [COORD_WIDTH-1:0]                    top_edge,
	output logic [tcmk_pkg::LEVEL_CNT_W-1:0]          level_count
);
	import tcmk_pkg::*;

	localparam int CFG_DW   = (COORD_WIDTH > 32) ? 64 : 32;
	localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2;
	localparam int ADDR_W   = IDX_W + ADDR_LSB;

	localparam logic [COORD_WIDTH-1:0] POS_ONE = ONE_FIXED[COORD_WIDTH-1:0];
	localparam logic [COORD_WIDTH-1:0] NEG_ONE = COORD_WIDTH'(64'd0 - ONE_FIXED);

	logic [COORD_WIDTH-1:0] left_edge_q, right_edge_q, bottom_edge_q, top_edge_q;
	logic [LEVEL_CNT_W-1:0] level_count_q;
	reg_idx_t               idx;
	logic                   wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
	assign wr_en = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q   <= NEG_ONE;
			right_edge_q  <= POS_ONE;
			bottom_edge_q <= NEG_ONE;
			top_edge_q    <= POS_ONE;
			level_count_q <= LEVEL_CNT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_LEFT_EDGE:   left_edge_q   <= pwdata[COORD_WIDTH-1:0];
				REG_RIGHT_EDGE:  right_edge_q  <= pwdata[COORD_WIDTH-1:0];
				REG_BOTTOM_EDGE: bottom_edge_q <= pwdata[COORD_WIDTH-1:0];
				REG_TOP_EDGE:    top_edge_q    <= pwdata[COORD_WIDTH-1:0];
				REG_LEVEL_COUNT: level_count_q <= pwdata[LEVEL_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LEFT_EDGE:   prdata = CFG_DW'(left_edge_q);
			REG_RIGHT_EDGE:  prdata = CFG_DW'(right_edge_q);
			REG_BOTTOM_EDGE: prdata = CFG_DW'(bottom_edge_q);
			REG_TOP_EDGE:    prdata = CFG_DW'(top_edge_q);
			REG_LEVEL_COUNT: prdata = CFG_DW'(level_count_q);
			default:         prdata = '0;
		endcase
	end

	assign left_edge   = left_edge_q;
	assign right_edge  = right_edge_q;
	assign bottom_edge = bottom_edge_q;
	assign top_edge    = top_edge_q;
	assign level_count = level_count_q;

endmodule

// ===== rtl/tcmk_corner_sum.sv =====
// First pipeline stage: exact sums of the three corner coordinates per axis.
// Also latches the starting bounding box; depends on no package.
module tcmk_corner_sum #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  logic [COORD_WIDTH-1:0] corner_a_x,
	input  logic [COORD_WIDTH-1:0] corner_a_y,
	input  logic [COORD_WIDTH-1:0] corner_b_x,
	input  logic [COORD_WIDTH-1:0] corner_b_y,
	input  logic [COORD_WIDTH-1:0] corner_c_x,
	input  logic [COORD_WIDTH-1:0] corner_c_y,
	input  logic [COORD_WIDTH-1:0] left_edge,
	input  logic [COORD_WIDTH-1:0] right_edge,
	input  logic [COORD_WIDTH-1:0] bottom_edge,
	input  logic [COORD_WIDTH-1:0] top_edge,
	output logic [COORD_WIDTH+1:0] sum_x,
	output logic [COORD_WIDTH+1:0] sum_y,
	output logic [COORD_WIDTH-1:0] min_x,
	output logic [COORD_WIDTH-1:0] max_x,
	output logic [COORD_WIDTH-1:0] min_y,
	output logic [COORD_WIDTH-1:0] max_y
);
	localparam int SW = COORD_WIDTH + 2;

	logic          valid_s1;
	logic [SW-1:0] sum_x_s1, sum_y_s1, sum_x_d, sum_y_d;
	logic [COORD_WIDTH-1:0] min_x_s1, max_x_s1, min_y_s1, max_y_s1;

	assign sum_x_d = {{2{corner_a_x[COORD_WIDTH-1]}}, corner_a_x}
		+ {{2{corner_b_x[COORD_WIDTH-1]}}, corner_b_x}
		+ {{2{corner_c_x[COORD_WIDTH-1]}}, corner_c_x};
	assign sum_y_d = {{2{corner_a_y[COORD_WIDTH-1]}}, corner_a_y}
		+ {{2{corner_b_y[COORD_WIDTH-1]}}, corner_b_y}
		+ {{2{corner_c_y[COORD_WIDTH-1]}}, corner_c_y};

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_x_s1 <= sum_x_d;
			sum_y_s1 <= sum_y_d;
			min_x_s1 <= left_edge;
			max_x_s1 <= right_edge;
			min_y_s1 <= bottom_edge;
			max_y_s1 <= top_edge;
		end
	end

	assign out_valid = valid_s1;
	assign sum_x = sum_x_s1;
	assign sum_y = sum_y_s1;
	assign min_x = min_x_s1;
	assign max_x = max_x_s1;
	assign min_y = min_y_s1;
	assign max_y = max_y_s1;

endmodule

// ===== rtl/tcmk_level.sv =====
// One bisection level as a pipeline stage: compares the centroid with the box
// centre, appends key bits if active and halves the box. Depends on tcmk_pkg.
module tcmk_level #(
	parameter int COORD_WIDTH = 32,
	parameter int LEVEL       = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  logic [tcmk_pkg::LEVEL_CNT_W-1:0] level_count,
	input  logic [COORD_WIDTH+1:0]           sum_x_i,
	input  logic [COORD_WIDTH+1:0]           sum_y_i,
	input  logic [COORD_WIDTH-1:0]           min_x_i,
	input  logic [COORD_WIDTH-1:0]           max_x_i,
	input  logic [COORD_WIDTH-1:0]           min_y_i,
	input  logic [COORD_WIDTH-1:0]           max_y_i,
	input  logic [tcmk_pkg::KEY_W-1:0]       key_i,
	output logic [COORD_WIDTH+1:0]           sum_x_o,
	output logic [COORD_WIDTH+1:0]           sum_y_o,
	output logic [COORD_WIDTH-1:0]           min_x_o,
	output logic [COORD_WIDTH-1:0]           max_x_o,
	output logic [COORD_WIDTH-1:0]           min_y_o,
	output logic [COORD_WIDTH-1:0]           max_y_o,
	output logic [tcmk_pkg::KEY_W-1:0]       key_o
);
	import tcmk_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int TW = COORD_WIDTH + 3;

	logic                valid_s1;
	logic [W:0]          mid_x_sum, mid_y_sum;
	logic [W-1:0]        mid_x, mid_y;
	logic signed [TW-1:0] mid_x_e, mid_y_e, thr_x, thr_y, sum_x_e, sum_y_e;
	logic                x_high, y_high, active;
	logic [W+1:0]        sum_x_s1, sum_y_s1;
	logic [W-1:0]        min_x_s1, max_x_s1, min_y_s1, max_y_s1;
	logic [KEY_W-1:0]    key_s1;

	// The floored centroid exceeds the centre exactly when the corner sum
	// exceeds three times the centre plus two, so no division is needed.
	assign mid_x_sum = {min_x_i[W-1], min_x_i} + {max_x_i[W-1], max_x_i};
	assign mid_y_sum = {min_y_i[W-1], min_y_i} + {max_y_i[W-1], max_y_i};
	assign mid_x     = mid_x_sum[W:1];
	assign mid_y     = mid_y_sum[W:1];
	assign mid_x_e   = $signed({{3{mid_x[W-1]}}, mid_x});
	assign mid_y_e   = $signed({{3{mid_y[W-1]}}, mid_y});
	assign thr_x     = (mid_x_e <<< 1) + mid_x_e + TW'(2);
	assign thr_y     = (mid_y_e <<< 1) + mid_y_e + TW'(2);
	assign sum_x_e   = $signed({sum_x_i[W+1], sum_x_i});
	assign sum_y_e   = $signed({sum_y_i[W+1], sum_y_i});
	assign x_high    = sum_x_e > thr_x;
	assign y_high    = sum_y_e > thr_y;
	assign active    = level_count > LEVEL_CNT_W'(LEVEL);

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_x_s1 <= sum_x_i;
			sum_y_s1 <= sum_y_i;
			min_x_s1 <= x_high ? mid_x : min_x_i;
			max_x_s1 <= x_high ? max_x_i : mid_x;
			min_y_s1 <= y_high ? mid_y : min_y_i;
			max_y_s1 <= y_high ? max_y_i : mid_y;
			key_s1   <= active ? {key_i[KEY_W-BITS_PER_LEVEL-1:0], 1'b0, y_high, x_high}
				: key_i;
		end
	end

	assign out_valid = valid_s1;
	assign sum_x_o   = sum_x_s1;
	assign sum_y_o   = sum_y_s1;
	assign min_x_o   = min_x_s1;
	assign max_x_o   = max_x_s1;
	assign min_y_o   = min_y_s1;
	assign max_y_o   = max_y_s1;
	assign key_o     = key_s1;

endmodule

// ===== rtl/triangle_centroid_morton_key_top.sv =====
// Top level of the triangle centroid curve key block.
// Instantiates tcmk_cfg_regs, tcmk_corner_sum and tcmk_level; depends on tcmk_pkg.
//
// Each slave-side transaction carries the six corner coordinates of one
// triangle; each master-side transaction carries its curve key. The key is
// built by bisecting the configured bounding box, three key bits per level,
// with the first level in the most significant bits.
//
// The pipeline has MAX_LEVELS + 1 register stages: one that sums the corners
// and one per bisection level, each holding one add of the box edges and one
// add and compare against the corner sum. One transaction per cycle is
// accepted and delivered in steady state while the receiver does not stall.
//
// Reset returns the registers to the unit box from -1.0 to 1.0 with 20 levels
// and empties the pipeline. On a stall each stage holds its item while empty
// stages keep filling; s_tready drops only once all stages hold items. The
// user, not the block, keeps APB-style port register writes to idle periods.
module triangle_centroid_morton_key_top #(
	parameter int MAX_LEVELS  = 20,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 s_tvalid,
	output logic                                                 s_tready,
	// Fields from bit 0: corner_a_x, corner_a_y, corner_b_x, corner_b_y,
	// corner_c_x, corner_c_y, zero fill.
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]                   s_tdata,
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	// Fields from bit 0: curve_key, zero fill.
	output logic [tcmk_pkg::OUT_TDATA_W-1:0]                     m_tdata,
	input  logic                                                 psel,
	input  logic                                                 penable,
	input  logic                                                 pwrite,
	input  logic [tcmk_pkg::IDX_W+((COORD_WIDTH>32)?3:2)-1:0]    paddr,
	input  logic [((COORD_WIDTH>32)?64:32)-1:0]                  pwdata,
	output logic [((COORD_WIDTH>32)?64:32)-1:0]                  prdata,
	output logic                                                 pready
);
	import tcmk_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int NS = MAX_LEVELS + 1;

	logic [W-1:0]             left_edge, right_edge, bottom_edge, top_edge;
	logic [LEVEL_CNT_W-1:0]   level_count;
	logic [NS-1:0]            stage_valid;
	logic [NS:1]              stage_ready;
	logic [NS-1:0][W+1:0]     sum_x, sum_y;
	logic [NS-1:0][W-1:0]     min_x, max_x, min_y, max_y;
	logic [NS-1:0][KEY_W-1:0] key;

	tcmk_cfg_regs #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.left_edge  (left_edge),
		.right_edge (right_edge),
		.bottom_edge(bottom_edge),
		.top_edge   (top_edge),
		.level_count(level_count)
	);

	tcmk_corner_sum #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_sum (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.out_valid   (stage_valid[0]),
		.out_ready   (stage_ready[1]),
		.corner_a_x  (s_tdata[0*W +: W]),
		.corner_a_y  (s_tdata[1*W +: W]),
		.corner_b_x  (s_tdata[2*W +: W]),
		.corner_b_y  (s_tdata[3*W +: W]),
		.corner_c_x  (s_tdata[4*W +: W]),
		.corner_c_y  (s_tdata[5*W +: W]),
		.left_edge   (left_edge),
		.right_edge  (right_edge),
		.bottom_edge (bottom_edge),
		.top_edge    (top_edge),
		.sum_x       (sum_x[0]),
		.sum_y       (sum_y[0]),
		.min_x       (min_x[0]),
		.max_x       (max_x[0]),
		.min_y       (min_y[0]),
		.max_y       (max_y[0])
	);

	assign key[0]          = '0;
	assign stage_ready[NS] = m_tready;

	for (genvar g = 1; g < NS; g++) begin : g_level
		tcmk_level #(
			.COORD_WIDTH(COORD_WIDTH),
			.LEVEL      (g - 1)
		) u_level (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (stage_valid[g-1]),
			.in_ready   (stage_ready[g]),
			.out_valid  (stage_valid[g]),
			.out_ready  (stage_ready[g+1]),
			.level_count(level_count),
			.sum_x_i    (sum_x[g-1]),
			.sum_y_i    (sum_y[g-1]),
			.min_x_i    (min_x[g-1]),
			.max_x_i    (max_x[g-1]),
			.min_y_i    (min_y[g-1]),
			.max_y_i    (max_y[g-1]),
			.key_i      (key[g-1]),
			.sum_x_o    (sum_x[g]),
			.sum_y_o    (sum_y[g]),
			.min_x_o    (min_x[g]),
			.max_x_o    (max_x[g]),
			.min_y_o    (min_y[g]),
			.max_y_o    (max_y[g]),
			.key_o      (key[g])
		);
	end

	assign m_tvalid = stage_valid[NS-1];
	assign m_tdata  = {{(OUT_TDATA_W-KEY_W){1'b0}}, key[NS-1]};

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&stage_valid))
		else $error("Input blocked while a pipeline stage is empty.");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> stage_valid[0])
		else $error("Accepted transaction did not reach the first stage.");

	a_spare_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((key[NS-1] & key_spare_mask()) == '0))
		else $error("Spare key bit set in an output transaction.");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(key[NS-1]))
		else $error("Stalled result changed or dropped.");

endmodule
